### rtl/mlpf_pkg.sv
// Shared widths, codes, types and helpers for the leaky ReLU network engine.
package mlpf_pkg;

  localparam int NODE_W         = 4;
  localparam int MAX_WIDTH      = 2 ** NODE_W;
  localparam int LEN_W          = NODE_W + 1;
  localparam int VALUE_BITS     = 16;
  localparam int FRAC_BITS      = 12;
  localparam int MAX_LAYERS_DEF = 4;
  localparam int ACC_W          = 2 * VALUE_BITS + NODE_W + 2;

  // divide a magnitude up to 2**(VALUE_BITS-1) by 100: (m * LEAK_RECIP) >> LEAK_SHIFT
  localparam int LEAK_SHIFT = 22;
  localparam logic [VALUE_BITS-1:0] LEAK_RECIP = VALUE_BITS'(41944);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd3;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [NODE_W-1:0] node;
  } mac_tag_t;

  typedef struct packed {
    logic                         valid;
    logic [NODE_W-1:0]            node;
    logic signed [VALUE_BITS-1:0] value;
  } node_wr_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_WIDTH)) begin
      r = LEN_W'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/mlpf_mem.sv
// Node value and weight memories, one write and one registered read port each.
module mlpf_mem import mlpf_pkg::*; #(
  parameter int MAX_LAYERS = MAX_LAYERS_DEF,
  localparam int N_DEPTH = MAX_LAYERS * MAX_WIDTH,
  localparam int W_DEPTH = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH,
  localparam int NA_W    = $clog2(N_DEPTH),
  localparam int WA_W    = $clog2(W_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         node_we_i,
  input  logic [NA_W-1:0]              node_waddr_i,
  input  logic signed [VALUE_BITS-1:0] node_wdata_i,
  input  logic [NA_W-1:0]              node_raddr_i,
  output logic signed [VALUE_BITS-1:0] node_rdata_o,
  input  logic                         weight_we_i,
  input  logic [WA_W-1:0]              weight_waddr_i,
  input  logic signed [VALUE_BITS-1:0] weight_wdata_i,
  input  logic [WA_W-1:0]              weight_raddr_i,
  output logic signed [VALUE_BITS-1:0] weight_rdata_o
);

  logic signed [VALUE_BITS-1:0] node_mem   [N_DEPTH];
  logic signed [VALUE_BITS-1:0] weight_mem [W_DEPTH];

  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      node_mem[node_waddr_i] <= node_wdata_i;
    end
    node_rdata_o <= node_mem[node_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (weight_we_i) begin
      weight_mem[weight_waddr_i] <= weight_wdata_i;
    end
    weight_rdata_o <= weight_mem[weight_raddr_i];
  end

endmodule

### rtl/mlpf_mac.sv
// Multiply-accumulate pipeline with truncating shift, saturation and leaky ReLU.
module mlpf_mac import mlpf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_tag_t                     issue_i,
  input  logic signed [VALUE_BITS-1:0] node_rd_i,
  input  logic signed [VALUE_BITS-1:0] weight_rd_i,
  input  logic signed [VALUE_BITS-1:0] bias_i,
  output node_wr_t                     wr_o,
  output logic                         busy_o
);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (VALUE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  mac_tag_t                       p1_q, p2_q;
  logic signed [2*VALUE_BITS-1:0] prod_q;
  logic signed [ACC_W-1:0]        acc_q, acc_base, bias_ext, shifted;
  logic                           p3_valid_q, f1_valid_q, f2_valid_q;
  logic [NODE_W-1:0]              p3_node_q, f1_node_q, f2_node_q;
  logic signed [VALUE_BITS-1:0]   sat_d, sat_q, sat2_q, leak_val;
  logic [VALUE_BITS-1:0]          mag;
  logic [2*VALUE_BITS-1:0]        leak_q;
  logic                           neg_q;

  assign bias_ext = ACC_W'(bias_i) <<< FRAC_BITS;
  assign acc_base = p2_q.first ? bias_ext : acc_q;
  assign shifted  = acc_q >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_d = VALUE_BITS'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat_d = VALUE_BITS'(SAT_LO);
    end else begin
      sat_d = VALUE_BITS'(shifted);
    end
  end

  assign mag      = -sat_q;
  assign leak_val = VALUE_BITS'(leak_q >> LEAK_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q       <= '0;
      p2_q       <= '0;
      p3_valid_q <= 1'b0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      p1_q       <= issue_i;
      p2_q       <= p1_q;
      p3_valid_q <= p2_q.valid && p2_q.last;
      f1_valid_q <= p3_valid_q;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= node_rd_i * weight_rd_i;
    if (p2_q.valid) begin
      acc_q <= acc_base + ACC_W'(prod_q);
    end
    p3_node_q <= p2_q.node;
    sat_q     <= sat_d;
    f1_node_q <= p3_node_q;
    leak_q    <= (2 * VALUE_BITS)'(mag) * (2 * VALUE_BITS)'(LEAK_RECIP);
    neg_q     <= sat_q[VALUE_BITS-1];
    sat2_q    <= sat_q;
    f2_node_q <= f1_node_q;
  end

  assign wr_o.valid = f2_valid_q;
  assign wr_o.node  = f2_node_q;
  assign wr_o.value = neg_q ? -leak_val : sat2_q;

  assign busy_o = p1_q.valid || p2_q.valid || p3_valid_q || f1_valid_q || f2_valid_q;

endmodule

### rtl/mlp_forward_leaky_relu.sv
// Top level: configuration, load decode, forward pass sequencer and result register.
// Load transfers are accepted whenever the block is idle.
// Run: per layer src_len * dst_len MAC issues (one weight per cycle, one node and one
// weight read each), a drain until the MAC is idle, then each result via S_ORD and S_OLD.
// Results leave through a register; the last one may wait while new loads are taken.
// Reset restores the configuration defaults; node, weight and bias stores are not cleared.
module mlp_forward_leaky_relu import mlpf_pkg::*; #(
  parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [1:0]                   layer_sel_i,
  input  logic [NODE_W-1:0]            from_node_i,
  input  logic [NODE_W-1:0]            to_node_i,
  input  logic signed [VALUE_BITS-1:0] data_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [NODE_W-1:0]            out_index_o,
  output logic signed [VALUE_BITS-1:0] out_value_o,
  output logic                         last_o
);

  localparam int LW      = $clog2(MAX_LAYERS);
  localparam int LSRC_W  = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS - 1) : 1;
  localparam int NW      = $clog2(MAX_LAYERS + 1);
  localparam int NA_W    = $clog2(MAX_LAYERS * MAX_WIDTH);
  localparam int WA_W    = $clog2((MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ORD   = 5'b01000,
    S_OLD   = 5'b10000
  } state_e;

  function automatic logic [LEN_W-1:0] len_of(input logic [NW-1:0] l, input logic [NW-1:0] n,
                                               input logic [LEN_W-1:0] in_len,
                                               input logic [LEN_W-1:0] hid_len,
                                               input logic [LEN_W-1:0] out_len);
    logic [LEN_W-1:0] r;
    if (l == '0) begin
      r = clamp_len(in_len);
    end else if (l == n - NW'(1)) begin
      r = clamp_len(out_len);
    end else begin
      r = clamp_len(hid_len);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [2:0]        layer_count_q;
  logic [LEN_W-1:0]  input_length_q, hidden_length_q, output_length_q;
  logic [LW-1:0]     l_q, l_d;
  logic [NODE_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [VALUE_BITS-1:0] bias_q [MAX_LAYERS-1];

  logic [NW-1:0]    n_eff, l_ext, lsel_ext;
  logic [LEN_W-1:0] src_len, dst_len, out_len, sel_len, sel_next_len, in_len;
  logic             in_acc, out_acc, cfg_acc, lsel_ok;
  logic             weight_we, input_we, busy, out_load;
  logic [LW-1:0]    out_layer;
  mac_tag_t         issue;
  node_wr_t         mac_wr;

  logic                         node_we;
  logic [NA_W-1:0]              node_waddr, node_raddr;
  logic signed [VALUE_BITS-1:0] node_wdata, node_rdata, weight_rdata;
  logic [WA_W-1:0]              weight_waddr, weight_raddr;

  logic                         out_valid_q;
  logic [NODE_W-1:0]            out_index_q;
  logic signed [VALUE_BITS-1:0] out_value_q;
  logic                         last_q;

  always_comb begin
    if (layer_count_q < 3'd2) begin
      n_eff = NW'(2);
    end else if (int'(layer_count_q) > MAX_LAYERS) begin
      n_eff = NW'(MAX_LAYERS);
    end else begin
      n_eff = NW'(layer_count_q);
    end
  end

  assign l_ext        = NW'(l_q);
  assign lsel_ext     = NW'(layer_sel_i);
  assign src_len      = len_of(l_ext, n_eff, input_length_q, hidden_length_q, output_length_q);
  assign dst_len      = len_of(l_ext + NW'(1), n_eff, input_length_q, hidden_length_q,
                               output_length_q);
  assign out_len      = len_of(n_eff - NW'(1), n_eff, input_length_q, hidden_length_q,
                               output_length_q);
  assign sel_len      = len_of(lsel_ext, n_eff, input_length_q, hidden_length_q,
                               output_length_q);
  assign sel_next_len = len_of(lsel_ext + NW'(1), n_eff, input_length_q, hidden_length_q,
                               output_length_q);
  assign in_len       = clamp_len(input_length_q);
  assign out_layer    = LW'(n_eff - NW'(1));

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;

  assign lsel_ok   = int'(layer_sel_i) < int'(n_eff) - 1;
  assign weight_we = in_acc && (operation_i == OP_WEIGHT) && lsel_ok &&
                     ({1'b0, from_node_i} < sel_len) && ({1'b0, to_node_i} < sel_next_len);
  assign input_we  = in_acc && (operation_i == OP_INPUT) && ({1'b0, to_node_i} < in_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q   <= 3'd2;
      input_length_q  <= LEN_W'(1);
      hidden_length_q <= LEN_W'(1);
      output_length_q <= LEN_W'(1);
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_LAYER_COUNT:   layer_count_q   <= cfg_data_i[2:0];
        CFG_INPUT_LENGTH:  input_length_q  <= cfg_data_i;
        CFG_HIDDEN_LENGTH: hidden_length_q <= cfg_data_i;
        CFG_OUTPUT_LENGTH: output_length_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == OP_BIAS) && lsel_ok) begin
      bias_q[LSRC_W'(layer_sel_i)] <= data_value_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    l_d      = l_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    out_load = 1'b0;
    issue    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (operation_i == OP_RUN)) begin
          l_d     = '0;
          i_d     = '0;
          j_d     = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        issue.valid = 1'b1;
        issue.first = (i_q == '0);
        issue.last  = ({1'b0, i_q} == src_len - LEN_W'(1));
        issue.node  = j_q;
        if (issue.last) begin
          i_d = '0;
          if ({1'b0, j_q} == dst_len - LEN_W'(1)) begin
            j_d     = '0;
            state_d = S_DRAIN;
          end else begin
            j_d = j_q + NODE_W'(1);
          end
        end else begin
          i_d = i_q + NODE_W'(1);
        end
      end
      S_DRAIN: begin
        if (!busy) begin
          if (l_ext + NW'(1) == n_eff - NW'(1)) begin
            k_d     = '0;
            state_d = S_ORD;
          end else begin
            l_d     = l_q + LW'(1);
            state_d = S_MAC;
          end
        end
      end
      S_ORD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_OLD;
        end
      end
      S_OLD: begin
        out_load = 1'b1;
        if ({1'b0, k_q} == out_len - LEN_W'(1)) begin
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + NODE_W'(1);
          state_d = S_ORD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      l_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= k_q;
      out_value_q <= node_rdata;
      last_q      <= ({1'b0, k_q} == out_len - LEN_W'(1));
    end
  end

  assign node_raddr   = (state_q == S_MAC) ? {l_q, i_q} : {out_layer, k_q};
  assign weight_raddr = WA_W'({LSRC_W'(l_q), i_q, j_q});
  assign weight_waddr = WA_W'({LSRC_W'(layer_sel_i), from_node_i, to_node_i});
  assign node_we      = mac_wr.valid || input_we;
  assign node_waddr   = mac_wr.valid ? {l_q + LW'(1), mac_wr.node} : {LW'(0), to_node_i};
  assign node_wdata   = mac_wr.valid ? mac_wr.value : data_value_i;

  mlpf_mem #(
    .MAX_LAYERS(MAX_LAYERS)
  ) u_mem (
    .clk_i          (clk_i),
    .node_we_i      (node_we),
    .node_waddr_i   (node_waddr),
    .node_wdata_i   (node_wdata),
    .node_raddr_i   (node_raddr),
    .node_rdata_o   (node_rdata),
    .weight_we_i    (weight_we),
    .weight_waddr_i (weight_waddr),
    .weight_wdata_i (data_value_i),
    .weight_raddr_i (weight_raddr),
    .weight_rdata_o (weight_rdata)
  );

  mlpf_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .node_rd_i   (node_rdata),
    .weight_rd_i (weight_rdata),
    .bias_i      (bias_q[LSRC_W'(l_q)]),
    .wr_o        (mac_wr),
    .busy_o      (busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule

### dv/tb_mlp_forward_leaky_relu.sv
// Testbench for the leaky ReLU network engine: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_mlp_forward_leaky_relu;
  import mlpf_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0]     idx;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } out_rec_t;

  typedef struct packed {
    op_e                   op;
    logic [1:0]            lsel;
    logic [NODE_W-1:0]     src;
    logic [NODE_W-1:0]     dst;
    logic [VALUE_BITS-1:0] data;
    logic                  has_exp;
    logic [VALUE_BITS-1:0] exp_value;
  } dir_row_t;

  typedef struct packed {
    logic [2:0] layers;
    logic [4:0] in_len;
    logic [4:0] hid_len;
    logic [4:0] out_len;
  } net_shape_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_SHAPES   = 7;
  localparam int RANDOM_ITEMS = 70;
  localparam int PHASE_ITEMS  = 10;
  localparam int HOLD_AT      = 12;
  localparam int HOLD_CYCLES  = 300;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_WEIGHT, 2'd0, 4'd0,  4'd0,  16'h1000, 1'b0, 16'h0000},
    '{OP_BIAS,   2'd0, 4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_INPUT,  2'd0, 4'd0,  4'd0,  16'h1000, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'h1000},
    '{OP_INPUT,  2'd0, 4'd0,  4'd0,  16'h7FFF, 1'b0, 16'h0000},
    '{OP_WEIGHT, 2'd0, 4'd0,  4'd0,  16'h7FFF, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'h7FFF},
    '{OP_INPUT,  2'd0, 4'd0,  4'd0,  16'h8000, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'hFEB9},
    '{OP_WEIGHT, 2'd1, 4'd0,  4'd0,  16'h1234, 1'b0, 16'h0000},
    '{OP_WEIGHT, 2'd3, 4'd15, 4'd15, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_WEIGHT, 2'd0, 4'd15, 4'd0,  16'h5555, 1'b0, 16'h0000},
    '{OP_WEIGHT, 2'd0, 4'd0,  4'd15, 16'hAAAA, 1'b0, 16'h0000},
    '{OP_BIAS,   2'd1, 4'd0,  4'd0,  16'h7FFF, 1'b0, 16'h0000},
    '{OP_BIAS,   2'd3, 4'd0,  4'd0,  16'h8000, 1'b0, 16'h0000},
    '{OP_INPUT,  2'd0, 4'd0,  4'd15, 16'h7FFF, 1'b0, 16'h0000},
    '{OP_INPUT,  2'd0, 4'd0,  4'd1,  16'h0001, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'hFEB9},
    '{OP_INPUT,  2'd0, 4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000},
    '{OP_BIAS,   2'd0, 4'd0,  4'd0,  16'h7FFF, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'h7FFF},
    '{OP_BIAS,   2'd0, 4'd0,  4'd0,  16'hFFFF, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'h0000},
    '{OP_BIAS,   2'd0, 4'd0,  4'd0,  16'hE700, 1'b0, 16'h0000},
    '{OP_RUN,    2'd0, 4'd0,  4'd0,  16'h0000, 1'b1, 16'hFFC0}
  };

  localparam net_shape_t NET_SHAPES [NUM_SHAPES] = '{
    '{3'd3, 5'd4,  5'd3,  5'd5},
    '{3'd0, 5'd31, 5'd0,  5'd0},
    '{3'd1, 5'd0,  5'd31, 5'd2},
    '{3'd7, 5'd2,  5'd1,  5'd16},
    '{3'd4, 5'd2,  5'd1,  5'd3},
    '{3'd2, 5'd16, 5'd5,  5'd1},
    '{3'd5, 5'd3,  5'd2,  5'd4}
  };

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_valid_i  = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i   = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [1:0]                   operation_i  = '0;
  logic [1:0]                   layer_sel_i  = '0;
  logic [NODE_W-1:0]            from_node_i  = '0;
  logic [NODE_W-1:0]            to_node_i    = '0;
  logic signed [VALUE_BITS-1:0] data_value_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [NODE_W-1:0]            out_index_o;
  logic signed [VALUE_BITS-1:0] out_value_o;
  logic                         last_o;

  mlp_forward_leaky_relu i_dut (.*);

  // network state mirror
  logic signed [VALUE_BITS-1:0] weight_mem [768];
  logic signed [VALUE_BITS-1:0] bias_mem   [3];
  logic signed [VALUE_BITS-1:0] node_mem   [64];
  bit                           weight_set [768];
  bit                           bias_set   [3];
  bit                           input_set  [16];
  logic [2:0]                   cur_layers  = 3'd2;
  logic [4:0]                   cur_in_len  = 5'd1;
  logic [4:0]                   cur_hid_len = 5'd1;
  logic [4:0]                   cur_out_len = 5'd1;

  out_rec_t pass_results    [$];
  out_rec_t pending_outputs [$];
  out_rec_t got_rec;
  out_rec_t want_rec;
  int       mismatch_count = 0;
  int       outputs_taken  = 0;
  int       hold_left      = 0;
  int       tx_idle        = 35;
  int       rx_idle        = 65;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[mlp_forward_leaky_relu] ERROR");
    $finish;
  end

  function automatic int unsigned eff_layers();
    if (cur_layers < 3'd2) return 2;
    if (cur_layers > 3'd4) return 4;
    return int'(cur_layers);
  endfunction

  function automatic int unsigned layer_len(int unsigned l);
    logic [4:0] v;
    if (l == 0) v = cur_in_len;
    else if (l == eff_layers() - 1) v = cur_out_len;
    else v = cur_hid_len;
    if (v == 5'd0) return 1;
    if (v > 5'd16) return 16;
    return int'(v);
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16'h3000)) - 16'h1800;
  endfunction

  // apply one item to the mirror; forward pass results go to pass_results
  function automatic bit network_step(op_e op, logic [1:0] lsel, logic [NODE_W-1:0] src,
                                      logic [NODE_W-1:0] dst, logic signed [15:0] data);
    int unsigned n;
    int unsigned l;
    int unsigned i;
    int unsigned j;
    int unsigned widx;
    longint      acc;
    longint      sum;
    int          s;
    out_rec_t    rec;
    n = eff_layers();
    case (op)
      OP_WEIGHT: begin
        if (lsel < n - 1 && src < layer_len(lsel) && dst < layer_len(lsel + 1)) begin
          widx = (int'(lsel) * 16 + int'(src)) * 16 + int'(dst);
          weight_mem[widx] = data;
          weight_set[widx] = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      OP_BIAS: begin
        if (lsel < n - 1) begin
          bias_mem[lsel] = data;
          bias_set[lsel] = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      OP_INPUT: begin
        if (dst < layer_len(0)) begin
          node_mem[dst] = data;
          input_set[dst] = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        for (l = 0; l + 1 < n; l++) begin
          for (j = 0; j < layer_len(l + 1); j++) begin
            acc = longint'(bias_mem[l]) * 4096;
            for (i = 0; i < layer_len(l); i++) begin
              acc += longint'(node_mem[l * 16 + i]) *
                     longint'(weight_mem[(l * 16 + i) * 16 + j]);
            end
            sum = acc >>> FRAC_BITS;
            if (sum > 32767) s = 32767;
            else if (sum < -32768) s = -32768;
            else s = int'(sum);
            if (s < 0) s = s / 100;
            node_mem[(l + 1) * 16 + j] = 16'(s);
          end
        end
        for (j = 0; j < layer_len(n - 1); j++) begin
          rec.idx   = 4'(j);
          rec.value = node_mem[(n - 1) * 16 + j];
          rec.last  = (j + 1 == layer_len(n - 1));
          pass_results.push_back(rec);
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic transfer_item(op_e op, logic [1:0] lsel, logic [NODE_W-1:0] src,
                               logic [NODE_W-1:0] dst, logic [VALUE_BITS-1:0] data,
                               bit has_exp, logic [VALUE_BITS-1:0] exp_value,
                               output bit took);
    out_rec_t rec;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    layer_sel_i  <= lsel;
    from_node_i  <= src;
    to_node_i    <= dst;
    data_value_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    pass_results.delete();
    took = network_step(op, lsel, src, dst, data);
    if (has_exp) begin
      rec.idx   = '0;
      rec.value = exp_value;
      rec.last  = 1'b1;
      pending_outputs.push_back(rec);
    end else begin
      while (pass_results.size() != 0) pending_outputs.push_back(pass_results.pop_front());
    end
  endtask

  // write every entry a forward pass will read that has not been written yet
  task automatic fill_unwritten();
    int unsigned n;
    int unsigned l;
    int unsigned i;
    int unsigned j;
    bit          took;
    n = eff_layers();
    for (i = 0; i < layer_len(0); i++) begin
      if (!input_set[i]) transfer_item(OP_INPUT, 2'd0, '0, 4'(i), rand_value(), 1'b0, '0, took);
    end
    for (l = 0; l + 1 < n; l++) begin
      if (!bias_set[l]) transfer_item(OP_BIAS, 2'(l), '0, '0, rand_value(), 1'b0, '0, took);
      for (i = 0; i < layer_len(l); i++) begin
        for (j = 0; j < layer_len(l + 1); j++) begin
          if (!weight_set[(l * 16 + i) * 16 + j]) begin
            transfer_item(OP_WEIGHT, 2'(l), 4'(i), 4'(j), rand_value(), 1'b0, '0, took);
          end
        end
      end
    end
  endtask

  task automatic issue_item(op_e op, logic [1:0] lsel, logic [NODE_W-1:0] src,
                            logic [NODE_W-1:0] dst, logic [VALUE_BITS-1:0] data,
                            bit has_exp, logic [VALUE_BITS-1:0] exp_value,
                            output bit took);
    if (op == OP_RUN) fill_unwritten();
    transfer_item(op, lsel, src, dst, data, has_exp, exp_value, took);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LAYER_COUNT:   cur_layers  = value[2:0];
      CFG_INPUT_LENGTH:  cur_in_len  = value;
      CFG_HIDDEN_LENGTH: cur_hid_len = value;
      default:           cur_out_len = value;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        outputs_taken++;
        got_rec = '{out_index_o, out_value_o, last_o};
        if (pending_outputs.size() == 0) begin
          note_mismatch($sformatf("unexpected result: index %0d value %h last %b",
                                  out_index_o, out_value_o, last_o));
        end else begin
          want_rec = pending_outputs.pop_front();
          if (got_rec.idx !== want_rec.idx || got_rec.value !== want_rec.value ||
              got_rec.last !== want_rec.last) begin
            note_mismatch($sformatf(
              "result mismatch: expected index %0d value %h last %b, got %0d %h %b",
              want_rec.idx, want_rec.value, want_rec.last,
              got_rec.idx, got_rec.value, got_rec.last));
          end
        end
        if (outputs_taken == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  initial begin
    int         k;
    int         phase;
    int         effective;
    int         phase_count;
    int         guard;
    int unsigned n;
    int unsigned l;
    int unsigned r;
    bit         took;
    op_e        op;
    logic [1:0] lsel;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [VALUE_BITS-1:0] data;
    net_shape_t shape;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      issue_item(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].lsel, DIRECTED_ROWS[k].src,
                 DIRECTED_ROWS[k].dst, DIRECTED_ROWS[k].data, DIRECTED_ROWS[k].has_exp,
                 DIRECTED_ROWS[k].exp_value, took);
    end

    phase = 0;
    effective = 0;
    while (effective < RANDOM_ITEMS || phase < NUM_SHAPES) begin
      wait_idle();
      if (phase < 3) begin
        tx_idle = 35;
        rx_idle = 65;
      end else if (phase < 6) begin
        tx_idle = 65;
        rx_idle = 35;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (phase < NUM_SHAPES) begin
        shape = NET_SHAPES[phase];
      end else begin
        shape = '{3'($urandom_range(0, 7)), 5'($urandom_range(0, 6)),
                  5'($urandom_range(0, 6)), 5'($urandom_range(0, 6))};
      end
      write_reg(CFG_LAYER_COUNT, {2'b00, shape.layers});
      write_reg(CFG_INPUT_LENGTH, shape.in_len);
      write_reg(CFG_HIDDEN_LENGTH, shape.hid_len);
      write_reg(CFG_OUTPUT_LENGTH, shape.out_len);
      cfg_valid_i <= 1'b0;

      n = eff_layers();
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        r    = $urandom_range(0, 99);
        op   = OP_RUN;
        lsel = '0;
        src  = '0;
        dst  = '0;
        data = rand_value();
        if (r < 30) begin
          op   = OP_WEIGHT;
          l    = $urandom_range(0, n - 2);
          lsel = 2'(l);
          src  = 4'($urandom_range(0, layer_len(l) - 1));
          dst  = 4'($urandom_range(0, layer_len(l + 1) - 1));
        end else if (r < 40) begin
          op   = OP_BIAS;
          lsel = 2'($urandom_range(0, n - 2));
        end else if (r < 60) begin
          op  = OP_INPUT;
          dst = 4'($urandom_range(0, layer_len(0) - 1));
        end else if (r >= 80) begin
          op   = op_e'($urandom_range(0, 3));
          lsel = 2'($urandom_range(0, 3));
          src  = 4'($urandom_range(0, 15));
          dst  = 4'($urandom_range(0, 15));
          data = 16'($urandom);
        end
        issue_item(op, lsel, src, dst, data, 1'b0, '0, took);
        if (took) begin
          phase_count++;
          effective++;
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_outputs.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
    while (pending_outputs.size() != 0) begin
      want_rec = pending_outputs.pop_front();
      note_mismatch($sformatf("missing result: index %0d value %h last %b",
                              want_rec.idx, want_rec.value, want_rec.last));
    end

    if (mismatch_count == 0) begin
      $display("[mlp_forward_leaky_relu] OK");
    end else begin
      $display("[mlp_forward_leaky_relu] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/mlpf_pkg.sv
rtl/mlpf_mem.sv
rtl/mlpf_mac.sv
rtl/mlp_forward_leaky_relu.sv
dv/tb_mlp_forward_leaky_relu.sv
